@@ hdl/vgst_pkg.sv @@
// shared types and constants of the voxel grid surface tracker
`default_nettype none
package vgst_pkg;

  localparam int VOXEL_W = 32;
  localparam int COORD_IN_W = 4;
  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_DELETE = 2'd2
  } kind_t;

  // face directions around a cell
  typedef enum logic [2:0] {
    DIR_XM = 3'd0,
    DIR_XP = 3'd1,
    DIR_YM = 3'd2,
    DIR_YP = 3'd3,
    DIR_ZM = 3'd4,
    DIR_ZP = 3'd5
  } dir_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEL_RD,
    ST_DEL_CHK,
    ST_EMPTY_WR,
    ST_ENB_RD,
    ST_ENB_CHK,
    ST_FILL_WR,
    ST_PRB_START,
    ST_PRB_RD,
    ST_PRB_CHK,
    ST_PRB_DONE,
    ST_FNB_RD,
    ST_FNB_CHK,
    ST_FIN_RD,
    ST_FIN,
    ST_OOR
  } state_t;

  // strobes toward both memories (same addresses for both)
  typedef struct packed {
    logic vox_we;
    logic flg_we;
    logic flg_wd;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rpt_t;

endpackage
`default_nettype wire

@@ hdl/vgst_ram.sv @@
// generic simple dual port ram with registered read
`default_nettype none
module vgst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/vgst_ctrl.sv @@
// sequencer: clearing pass, read-modify-write of voxels and surface flags
`default_nettype none
module vgst_ctrl import vgst_pkg::*; #(
  parameter int GRID_SIDE = 16,
  parameter int AW = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [COORD_IN_W-1:0] cell_x,
  input  wire logic [COORD_IN_W-1:0] cell_y,
  input  wire logic [COORD_IN_W-1:0] cell_z,
  input  wire logic [VOXEL_W-1:0]    new_value,
  input  wire logic [VOXEL_W-1:0]    vox_rdata,
  input  wire logic                  flg_rdata,
  output logic                       busy,
  output mem_ctl_t                   ctl,
  output logic [AW-1:0]              waddr,
  output logic [AW-1:0]              raddr,
  output logic [VOXEL_W-1:0]         vox_wdata,
  output rpt_t                       rpt
);

  localparam int CW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam logic [CW-1:0] HI = CW'(GRID_SIDE - 1);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  // returns {in_grid, x, y, z} of the face neighbor in direction d
  function automatic logic [3*CW:0] step_coord(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y,
                                               input logic [CW-1:0] z,
                                               input dir_t d);
    logic [CW-1:0] nx;
    logic [CW-1:0] ny;
    logic [CW-1:0] nz;
    logic ok;
    nx = x;
    ny = y;
    nz = z;
    ok = 1'b1;
    case (d)
      DIR_XM: begin ok = (x != '0); nx = x - 1'b1; end
      DIR_XP: begin ok = (x != HI); nx = x + 1'b1; end
      DIR_YM: begin ok = (y != '0); ny = y - 1'b1; end
      DIR_YP: begin ok = (y != HI); ny = y + 1'b1; end
      DIR_ZM: begin ok = (z != '0); nz = z - 1'b1; end
      DIR_ZP: begin ok = (z != HI); nz = z + 1'b1; end
      default: ok = 1'b0;
    endcase
    return {ok, nx, ny, nz};
  endfunction

  function automatic logic [AW-1:0] cell_index(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y,
                                               input logic [CW-1:0] z);
    return AW'(x) + AW'(y) * AW'(GRID_SIDE) + AW'(z) * AW'(GRID_SIDE * GRID_SIDE);
  endfunction

  state_t state;
  state_t state_next;

  logic [AW-1:0]      clr_cnt;
  logic [CW-1:0]      cx, cy, cz;
  logic [VOXEL_W-1:0] value;
  dir_t               nb;
  dir_t               pj;
  logic               phase_nb;
  logic               exposed;

  logic [3*CW:0] nb_step;
  logic          nb_ok;
  logic [CW-1:0] nx, ny, nz;
  logic [CW-1:0] tx, ty, tz;
  logic [3*CW:0] pr_step;
  logic [AW-1:0] c_addr, nb_addr, pr_addr;
  logic          tgt_edge;
  logic          nb_last;
  logic          nb_adv;
  logic          in_range;

  assign nb_step = step_coord(cx, cy, cz, nb);
  assign nb_ok   = nb_step[3*CW];
  assign nx      = nb_step[3*CW-1:2*CW];
  assign ny      = nb_step[2*CW-1:CW];
  assign nz      = nb_step[CW-1:0];

  // probe target is the center itself or the current neighbor
  assign tx = phase_nb ? nx : cx;
  assign ty = phase_nb ? ny : cy;
  assign tz = phase_nb ? nz : cz;
  assign tgt_edge = (tx == '0) || (tx == HI) || (ty == '0) || (ty == HI) ||
                    (tz == '0) || (tz == HI);
  assign pr_step = step_coord(tx, ty, tz, pj);

  assign c_addr  = cell_index(cx, cy, cz);
  assign nb_addr = cell_index(nx, ny, nz);
  assign pr_addr = cell_index(pr_step[3*CW-1:2*CW], pr_step[2*CW-1:CW], pr_step[CW-1:0]);

  assign nb_last  = (nb == DIR_ZP);
  assign in_range = (32'(cell_x) < GRID_SIDE) && (32'(cell_y) < GRID_SIDE) &&
                    (32'(cell_z) < GRID_SIDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    rpt        = '0;
    nb_adv     = 1'b0;
    waddr      = c_addr;
    raddr      = c_addr;
    vox_wdata  = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        ctl.vox_we = 1'b1;
        ctl.flg_we = 1'b1;
        waddr      = clr_cnt;
        if (clr_cnt == LAST_CELL) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (!in_range) begin
            state_next = ST_OOR;
          end else if (kind == KIND_WRITE) begin
            state_next = (new_value != '0) ? ST_FILL_WR : ST_EMPTY_WR;
          end else if (kind == KIND_DELETE) begin
            state_next = ST_DEL_RD;
          end else begin
            state_next = ST_FIN_RD;
          end
        end
      end
      ST_DEL_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = ST_DEL_CHK;
      end
      ST_DEL_CHK: begin
        state_next = (vox_rdata != '0) ? ST_EMPTY_WR : ST_FIN_RD;
      end
      ST_EMPTY_WR: begin
        ctl.vox_we = 1'b1;
        ctl.flg_we = 1'b1;
        state_next = ST_ENB_RD;
      end
      ST_ENB_RD: begin
        raddr = nb_addr;
        if (nb_ok) begin
          ctl.rd_en  = 1'b1;
          state_next = ST_ENB_CHK;
        end else begin
          nb_adv     = 1'b1;
          state_next = nb_last ? ST_FIN_RD : ST_ENB_RD;
        end
      end
      ST_ENB_CHK: begin
        // filled neighbor of a fresh hole becomes surface
        waddr      = nb_addr;
        ctl.flg_we = (vox_rdata != '0);
        ctl.flg_wd = 1'b1;
        nb_adv     = 1'b1;
        state_next = nb_last ? ST_FIN_RD : ST_ENB_RD;
      end
      ST_FILL_WR: begin
        ctl.vox_we = 1'b1;
        vox_wdata  = value;
        state_next = ST_PRB_START;
      end
      ST_PRB_START: begin
        state_next = tgt_edge ? ST_PRB_DONE : ST_PRB_RD;
      end
      ST_PRB_RD: begin
        ctl.rd_en  = 1'b1;
        raddr      = pr_addr;
        state_next = ST_PRB_CHK;
      end
      ST_PRB_CHK: begin
        if (vox_rdata == '0 || pj == DIR_ZP) begin
          state_next = ST_PRB_DONE;
        end else begin
          state_next = ST_PRB_RD;
        end
      end
      ST_PRB_DONE: begin
        if (!phase_nb) begin
          ctl.flg_we = exposed;
          ctl.flg_wd = 1'b1;
          state_next = ST_FNB_RD;
        end else begin
          waddr      = nb_addr;
          ctl.flg_we = !exposed;
          ctl.flg_wd = 1'b0;
          nb_adv     = 1'b1;
          state_next = nb_last ? ST_FIN_RD : ST_FNB_RD;
        end
      end
      ST_FNB_RD: begin
        raddr = nb_addr;
        if (nb_ok) begin
          ctl.rd_en  = 1'b1;
          state_next = ST_FNB_CHK;
        end else begin
          nb_adv     = 1'b1;
          state_next = nb_last ? ST_FIN_RD : ST_FNB_RD;
        end
      end
      ST_FNB_CHK: begin
        // only a set flag may need clearing
        if (flg_rdata) begin
          state_next = ST_PRB_START;
        end else begin
          nb_adv     = 1'b1;
          state_next = nb_last ? ST_FIN_RD : ST_FNB_RD;
        end
      end
      ST_FIN_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        rpt.done   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_OOR: begin
        rpt.done   = 1'b1;
        rpt.zero   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      nb       <= DIR_XM;
      pj       <= DIR_XM;
      phase_nb <= 1'b0;
      exposed  <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (nb_adv) begin
        nb <= dir_t'(nb + 3'd1);
      end
      case (state)
        ST_IDLE: begin
          nb       <= DIR_XM;
          phase_nb <= 1'b0;
        end
        ST_PRB_START: begin
          exposed <= tgt_edge;
          pj      <= DIR_XM;
        end
        ST_PRB_CHK: begin
          if (vox_rdata == '0) begin
            exposed <= 1'b1;
          end
          pj <= dir_t'(pj + 3'd1);
        end
        ST_PRB_DONE: begin
          phase_nb <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload latch, no reset needed
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cx    <= CW'(cell_x);
      cy    <= CW'(cell_y);
      cz    <= CW'(cell_z);
      value <= new_value;
    end
  end

endmodule
`default_nettype wire

@@ hdl/voxel_grid_surface_tracker.sv @@
// Voxel grid surface tracker: a GRID_SIDE^3 grid of 32-bit voxel words with surface flags.
//
// A word is taken at a rising edge with start high and busy low: kind (read, write,
// delete), the cell coordinates and new_value. busy stays high until the result.
// The result word (cell_value, occupied, on_surface) is on the ports for exactly one
// cycle, marked by done; the receiver cannot hold it off.
// The time a write or delete takes is set by the single read port of the voxel memory:
// the surface update probes the face neighbors of the cell and of each flagged neighbor,
// one voxel read and one check per step; a target at the grid boundary skips its probe.
// One word is in flight at a time: the next word can be taken the cycle after done.
// A coordinate outside the grid returns all zero in the cycle after it is taken.
// After reset a clearing pass writes zero to all GRID_SIDE^3 cells (4096 at the default)
// of both memories, one cell a cycle; busy is high during the pass.
// Both stores are synchronous memories with a registered read.
`default_nettype none
module voxel_grid_surface_tracker import vgst_pkg::*; #(
  parameter int GRID_SIDE = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [COORD_IN_W-1:0] cell_x,
  input  wire logic [COORD_IN_W-1:0] cell_y,
  input  wire logic [COORD_IN_W-1:0] cell_z,
  input  wire logic [VOXEL_W-1:0]    new_value,
  output logic                       done,
  output logic [VOXEL_W-1:0]         cell_value,
  output logic                       occupied,
  output logic                       on_surface
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int AW = $clog2(CELLS);

  mem_ctl_t           ctl;
  rpt_t               rpt;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [VOXEL_W-1:0] vox_wdata;
  logic [VOXEL_W-1:0] vox_rdata;
  logic               flg_rdata;

  vgst_ctrl #(
    .GRID_SIDE(GRID_SIDE),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .kind(kind),
    .cell_x(cell_x),
    .cell_y(cell_y),
    .cell_z(cell_z),
    .new_value(new_value),
    .vox_rdata(vox_rdata),
    .flg_rdata(flg_rdata),
    .busy(busy),
    .ctl(ctl),
    .waddr(waddr),
    .raddr(raddr),
    .vox_wdata(vox_wdata),
    .rpt(rpt)
  );

  vgst_ram #(
    .WIDTH(VOXEL_W),
    .DEPTH(CELLS)
  ) u_voxel_ram (
    .clk(clk),
    .we(ctl.vox_we),
    .waddr(waddr),
    .wdata(vox_wdata),
    .re(ctl.rd_en),
    .raddr(raddr),
    .rdata(vox_rdata)
  );

  vgst_ram #(
    .WIDTH(1),
    .DEPTH(CELLS)
  ) u_flag_ram (
    .clk(clk),
    .we(ctl.flg_we),
    .waddr(waddr),
    .wdata(ctl.flg_wd),
    .re(ctl.rd_en),
    .raddr(raddr),
    .rdata(flg_rdata)
  );

  // out of grid cells report as empty
  assign done       = rpt.done;
  assign cell_value = rpt.zero ? '0 : vox_rdata;
  assign occupied   = (cell_value != '0);
  assign on_surface = !rpt.zero && flg_rdata;

endmodule
`default_nettype wire

@@ tb/voxel_surface_checker.sv @@
// checker for the voxel grid surface tracker: predicts each result word and compares it
`default_nettype none
module voxel_surface_checker import vgst_pkg::*; #(
  parameter int GRID_SIDE = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [COORD_IN_W-1:0] cell_x,
  input  wire logic [COORD_IN_W-1:0] cell_y,
  input  wire logic [COORD_IN_W-1:0] cell_z,
  input  wire logic [VOXEL_W-1:0]    new_value,
  input  wire logic                  done,
  input  wire logic [VOXEL_W-1:0]    cell_value,
  input  wire logic                  occupied,
  input  wire logic                  on_surface,
  output int                         mismatches,
  output int                         outstanding
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int SHOWN_MAX = 10;

  typedef struct packed {
    logic [VOXEL_W-1:0] value;
    logic               filled;
    logic               surface;
  } cell_report_t;

  logic [VOXEL_W-1:0] grid_words [CELLS];
  logic               surface_bits [CELLS];
  cell_report_t       expected_cells [$];
  int                 shown = 0;

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      grid_words[i] = '0;
      surface_bits[i] = 1'b0;
    end
  end

  function automatic int cell_index(int x, int y, int z);
    return x + y * GRID_SIDE + z * GRID_SIDE * GRID_SIDE;
  endfunction

  function automatic bit in_grid(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 && x < GRID_SIDE && y < GRID_SIDE && z < GRID_SIDE;
  endfunction

  function automatic bit is_filled(int x, int y, int z);
    return grid_words[cell_index(x, y, z)] != '0;
  endfunction

  function automatic void face_neighbor(int x, int y, int z, dir_t d,
                                        output int nx, output int ny, output int nz);
    nx = x;
    ny = y;
    nz = z;
    case (d)
      DIR_XM: nx = x - 1;
      DIR_XP: nx = x + 1;
      DIR_YM: ny = y - 1;
      DIR_YP: ny = y + 1;
      DIR_ZM: nz = z - 1;
      default: nz = z + 1;
    endcase
  endfunction

  // boundary cell, or a face neighbor is empty
  function automatic bit is_exposed(int x, int y, int z);
    int nx, ny, nz;
    if (x == 0 || y == 0 || z == 0 ||
        x == GRID_SIDE - 1 || y == GRID_SIDE - 1 || z == GRID_SIDE - 1) return 1'b1;
    for (int d = 0; d < 6; d++) begin
      face_neighbor(x, y, z, dir_t'(d), nx, ny, nz);
      if (!is_filled(nx, ny, nz)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void refresh_flags(int x, int y, int z);
    int nx, ny, nz;
    if (is_filled(x, y, z)) begin
      // own flag only ever set here, neighbors only ever cleared
      if (is_exposed(x, y, z)) surface_bits[cell_index(x, y, z)] = 1'b1;
      for (int d = 0; d < 6; d++) begin
        face_neighbor(x, y, z, dir_t'(d), nx, ny, nz);
        if (in_grid(nx, ny, nz) && surface_bits[cell_index(nx, ny, nz)] &&
            !is_exposed(nx, ny, nz))
          surface_bits[cell_index(nx, ny, nz)] = 1'b0;
      end
    end else begin
      surface_bits[cell_index(x, y, z)] = 1'b0;
      for (int d = 0; d < 6; d++) begin
        face_neighbor(x, y, z, dir_t'(d), nx, ny, nz);
        if (in_grid(nx, ny, nz) && is_filled(nx, ny, nz))
          surface_bits[cell_index(nx, ny, nz)] = 1'b1;
      end
    end
  endfunction

  function automatic cell_report_t apply_voxel_op(logic [KIND_W-1:0] op, int x, int y, int z,
                                                  logic [VOXEL_W-1:0] word);
    cell_report_t rep;
    int idx;
    rep = '0;
    if (!in_grid(x, y, z)) return rep;
    idx = cell_index(x, y, z);
    if (op == KIND_WRITE) begin
      grid_words[idx] = word;
      refresh_flags(x, y, z);
    end else if (op == KIND_DELETE && grid_words[idx] != '0) begin
      grid_words[idx] = '0;
      refresh_flags(x, y, z);
    end
    rep.value = grid_words[idx];
    rep.filled = grid_words[idx] != '0;
    rep.surface = surface_bits[idx];
    return rep;
  endfunction

  always @(posedge clk) begin
    cell_report_t want;
    int fails;
    fails = mismatches;
    if (rst) begin
      fails = 0;
    end else begin
      if (done) begin
        if (expected_cells.size() == 0) begin
          fails++;
          if (shown < SHOWN_MAX) begin
            $display("unexpected result word: value %h occupied %b surface %b",
                     cell_value, occupied, on_surface);
            shown++;
          end
        end else begin
          want = expected_cells.pop_front();
          if (cell_value !== want.value || occupied !== want.filled ||
              on_surface !== want.surface) begin
            fails++;
            if (shown < SHOWN_MAX) begin
              $display("result mismatch: expected value %h occupied %b surface %b, got %h %b %b",
                       want.value, want.filled, want.surface,
                       cell_value, occupied, on_surface);
              shown++;
            end
          end
        end
      end
      if (start && !busy)
        expected_cells.push_back(apply_voxel_op(kind, int'(cell_x), int'(cell_y),
                                                int'(cell_z), new_value));
    end
    mismatches <= fails;
    outstanding <= expected_cells.size();
  end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// top of the voxel grid surface tracker testbench: clock, reset, stimulus and verdict
`default_nettype none
module testbench import vgst_pkg::*;;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int RANDOM_WORDS = 1930;
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int SETTLE_CYCLES = 150;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [KIND_W-1:0]     kind = KIND_READ;
  logic [COORD_IN_W-1:0] cell_x = '0;
  logic [COORD_IN_W-1:0] cell_y = '0;
  logic [COORD_IN_W-1:0] cell_z = '0;
  logic [VOXEL_W-1:0]    new_value = '0;
  logic                  busy;
  logic                  done;
  logic [VOXEL_W-1:0]    cell_value;
  logic                  occupied;
  logic                  on_surface;
  int                    mismatches;
  int                    outstanding;
  int                    cycle_count = 0;

  voxel_grid_surface_tracker uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z), .new_value(new_value),
    .done(done), .cell_value(cell_value), .occupied(occupied), .on_surface(on_surface)
  );

  voxel_surface_checker checker_inst (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z), .new_value(new_value),
    .done(done), .cell_value(cell_value), .occupied(occupied), .on_surface(on_surface),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // holds start high until the word is taken; start stays high for a following word
  task automatic send_word(logic [KIND_W-1:0] op, int x, int y, int z,
                           logic [VOXEL_W-1:0] word);
    start <= 1'b1;
    kind <= op;
    cell_x <= x[COORD_IN_W-1:0];
    cell_y <= y[COORD_IN_W-1:0];
    cell_z <= z[COORD_IN_W-1:0];
    new_value <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every taken word has its result
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic int pick_coord(int base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return base + $urandom_range(0, 4);
    if (r < 90) return $urandom_range(0, 15);
    return $urandom_range(0, 1) ? 15 : 0;
  endfunction

  initial begin
    int burst_left;
    int bx, by, bz;
    int r;
    logic [KIND_W-1:0] op;
    logic [VOXEL_W-1:0] word;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // corners and the value extremes; first word waits out the clearing pass
    send_word(KIND_READ, 0, 0, 0, '0);
    send_word(KIND_WRITE, 0, 0, 0, 32'hFFFF_FFFF);
    send_word(KIND_WRITE, 15, 15, 15, 32'h0000_0001);
    send_word(KIND_READ, 15, 15, 15, 32'hFFFF_FFFF);
    send_word(KIND_DELETE, 0, 0, 0, '0);
    // delete of an empty cell, then a zero write to an empty cell
    send_word(KIND_DELETE, 0, 0, 0, '0);
    send_word(KIND_WRITE, 3, 3, 3, '0);
    send_word(KIND_SPARE, 15, 15, 15, 32'h1234_5678);
    // enclose an interior cell so its flag gets cleared
    send_word(KIND_WRITE, 5, 5, 5, 32'hA5A5_0000);
    send_word(KIND_WRITE, 4, 5, 5, 32'hA5A5_0001);
    send_word(KIND_WRITE, 6, 5, 5, 32'hA5A5_0002);
    send_word(KIND_WRITE, 5, 4, 5, 32'hA5A5_0003);
    send_word(KIND_WRITE, 5, 6, 5, 32'hA5A5_0004);
    send_word(KIND_WRITE, 5, 5, 4, 32'hA5A5_0005);
    send_word(KIND_WRITE, 5, 5, 6, 32'hA5A5_0006);
    send_word(KIND_READ, 5, 5, 5, '0);
    send_word(KIND_DELETE, 5, 5, 6, '0);
    send_word(KIND_READ, 5, 5, 5, '0);
    send_word(KIND_WRITE, 5, 5, 6, 32'h8000_0000);
    send_word(KIND_READ, 5, 5, 5, '0);
    // zero write over a filled cell flags all its neighbors
    send_word(KIND_WRITE, 5, 5, 5, '0);
    send_word(KIND_READ, 4, 5, 5, '0);
    send_word(KIND_WRITE, 15, 0, 15, 32'h7FFF_FFFF);
    drain_results();

    burst_left = 0;
    bx = 4;
    by = 4;
    bz = 4;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        // some bursts follow straight on, the rest after a random gap
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 17));
        if ($urandom_range(0, 5) == 0) begin
          bx = $urandom_range(0, 11);
          by = $urandom_range(0, 11);
          bz = $urandom_range(0, 11);
        end
      end
      if (n == RANDOM_WORDS / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < 50) op = KIND_WRITE;
      else if (r < 72) op = KIND_DELETE;
      else if (r < 95) op = KIND_READ;
      else op = KIND_SPARE;
      r = $urandom_range(0, 99);
      if (r < 10) word = '0;
      else if (r < 15) word = 32'hFFFF_FFFF;
      else word = $urandom;
      send_word(op, pick_coord(bx), pick_coord(by), pick_coord(bz), word);
      burst_left--;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ voxel_grid_surface_tracker.f @@
hdl/vgst_pkg.sv
hdl/vgst_ram.sv
hdl/vgst_ctrl.sv
hdl/voxel_grid_surface_tracker.sv
tb/voxel_surface_checker.sv
tb/testbench.sv
